### src/bfws_pkg.sv
// Shared types and constants for the bounded FIFO with statistics.
`default_nettype none

package bfws_pkg;

  // Field widths of the item types
  localparam int unsigned DataW  = 32;
  localparam int unsigned FillW  = 11;
  localparam int unsigned CountW = 32;

  // Default ring depth and reset value of the fill limit
  localparam int unsigned DefaultDepth = 1024;
  localparam logic [FillW-1:0] CapLimitReset = 11'd1024;

  // Operation codes
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdGet = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [DataW-1:0] value_in;
  } bfws_in_t;

  typedef struct packed {
    logic                    success;
    logic signed [DataW-1:0] value_out;
    logic [FillW-1:0]        fill_level;
    logic [CountW-1:0]       add_tries;
    logic [CountW-1:0]       get_tries;
    logic [CountW-1:0]       add_done;
    logic [CountW-1:0]       get_done;
  } bfws_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic load;    // result goes into the output register
  } bfws_ctl_t;

endpackage

`default_nettype wire

### src/bfws_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bfws_ctrl.sv
// Controller: accept/load sequencing and output valid.
`default_nettype none

module bfws_ctrl
  import bfws_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output bfws_ctl_t ctl_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StLoad = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, load;

  assign accept = in_valid_i && (state_q == StIdle);
  assign load   = (state_q == StLoad) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (load) begin
          state_d = StIdle;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q == StLoad);
  assign out_valid_o  = out_valid_q;
  assign ctl_o.accept = accept;
  assign ctl_o.load   = load;

endmodule

`default_nettype wire

### src/bfws_dp.sv
// Datapath: ring pointers, fill count, statistics counters, slot RAM, result register.
`default_nettype none

module bfws_dp
  import bfws_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bfws_ctl_t        ctl_i,
  input  wire bfws_in_t         in_item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [FillW-1:0] cfg_wdata_i,
  output bfws_out_t             out_item_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [31:0] DepthW = 32'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  logic [FillW-1:0]  cap_limit_q;
  logic [AW-1:0]     head_q, tail_q;
  logic [FillW-1:0]  count_q;
  logic [CountW-1:0] add_try_q, get_try_q, add_ok_q, get_ok_q;
  logic              pend_ok_q, pend_get_q;
  bfws_out_t         out_q;

  logic             is_get, can_add, can_get, add_ok, get_ok;
  logic [DataW-1:0] rdata;

  assign is_get  = (in_item_i.cmd == CmdGet);
  // limit saturates at the ring depth
  assign can_add = (count_q < cap_limit_q) && (32'(count_q) < DepthW);
  assign can_get = (count_q != '0);
  assign add_ok  = ctl_i.accept && !is_get && can_add;
  assign get_ok  = ctl_i.accept && is_get && can_get;

  bfws_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (add_ok),
    .waddr_i(tail_q),
    .wdata_i(in_item_i.value_in),
    .re_i   (get_ok),
    .raddr_i(head_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit_q <= CapLimitReset;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      add_try_q   <= '0;
      get_try_q   <= '0;
      add_ok_q    <= '0;
      get_ok_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_limit_q <= cfg_wdata_i;
      end
      if (ctl_i.accept) begin
        if (is_get) begin
          get_try_q <= get_try_q + 1'b1;
        end else begin
          add_try_q <= add_try_q + 1'b1;
        end
      end
      if (add_ok) begin
        tail_q   <= (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
        count_q  <= count_q + 1'b1;
        add_ok_q <= add_ok_q + 1'b1;
      end
      if (get_ok) begin
        head_q   <= (head_q == LastSlot) ? '0 : head_q + 1'b1;
        count_q  <= count_q - 1'b1;
        get_ok_q <= get_ok_q + 1'b1;
      end
    end
  end

  // outcome of the item in flight, used on the later load
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      pend_ok_q  <= add_ok || get_ok;
      pend_get_q <= is_get;
    end
    if (ctl_i.load) begin
      out_q.success    <= pend_ok_q;
      out_q.value_out  <= (pend_ok_q && pend_get_q) ? $signed(rdata) : '0;
      out_q.fill_level <= count_q;
      out_q.add_tries  <= add_try_q;
      out_q.get_tries  <= get_try_q;
      out_q.add_done   <= add_ok_q;
      out_q.get_done   <= get_ok_q;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

### src/bounded_fifo_with_stats.sv
// Top level of the bounded FIFO with statistics counters.
`default_nettype none

// A first-in first-out queue of 32-bit signed values held in a ring of DEPTH
// RAM slots. Each input item is an add (cmd = 0) or a get (cmd = 1). An add
// stores value_in unless the fill has reached the limit, which is the smaller
// of the capacity_limit register (reset 1024) and DEPTH; a get returns the
// oldest value unless the queue is empty. Every item yields exactly one result
// item with the outcome, the value removed (0 when none), the fill after the
// operation and four wrapping 32-bit counters: add attempts, get attempts,
// successful adds, successful gets. Lowering the limit below the current fill
// keeps the entries already held; adds are refused until gets drain below it.
// Timing: in the accept cycle the pointers, fill count and counters update and
// the slot RAM is written (add) or read (get); in the load state that follows,
// the registered RAM read data and the counters are loaded into the output
// register. The next item is accepted in the cycle after that load, even while
// the result still waits in the output register; the load cycle stretches only
// while an earlier result is still held there. The slot RAM is not cleared: a
// get only reads slots written by earlier adds.
// Write capacity_limit only while no item is in flight.

module bounded_fifo_with_stats
  import bfws_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input item channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bfws_in_t         in_item_i,
  // result item channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output bfws_out_t             out_item_o,
  // capacity_limit register write
  input  wire logic             cfg_we_i,
  input  wire logic [FillW-1:0] cfg_wdata_i
);

  bfws_ctl_t ctl;

  // Sequencing: accept, then load the output register
  bfws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ctl_o      (ctl)
  );

  // Ring storage, counters and result register
  bfws_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
